/* hdl/smfa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smfa_pkg
// Shared constants for the sign-magnitude fixed-point ALU: limb width and
// command codes.
// ----------------------------------------------------------------------------
package smfa_pkg;

    localparam int LIMB_BITS = 32;
    localparam int MAG_BITS  = 2 * LIMB_BITS;

    typedef logic [LIMB_BITS-1:0] limb_t;
    typedef logic [MAG_BITS-1:0]  mag_t;
    typedef logic [1:0]           cmd_t;

    // Command codes; the code above multiply also multiplies
    localparam cmd_t CMD_ADD = 2'd0;
    localparam cmd_t CMD_SUB = 2'd1;
    localparam cmd_t CMD_MUL = 2'd2;

endpackage : smfa_pkg
`default_nettype wire

/* hdl/sign_magnitude_fixed_point_alu_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sign_magnitude_fixed_point_alu_core
// Sign-magnitude fixed-point add, subtract and multiply on 32.32 operands.
//
//   channel   handshake        payload
//   -------   --------------   ------------------------------------------
//   operand   start / busy     command, a_sign, a_integer, a_fraction,
//                              b_sign, b_integer, b_fraction
//   result    done (strobe)    r_sign, r_integer, r_fraction
//
// One word is accepted every cycle; busy stays low, the pipeline never fills.
// Each result passes the input register, partial products, column sums and
// result register in order. The 64x64 product sets the length of that chain.
// Results appear in issue order, one cycle each on done; no stall path.
// Reset clears only the valid chain; payload registers are not reset.
// ----------------------------------------------------------------------------
module sign_magnitude_fixed_point_alu_core
#(
    parameter int LIMB_COUNT = 2
)
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    output logic              busy,
    input  smfa_pkg::cmd_t    command,
    input  wire               a_sign,
    input  smfa_pkg::limb_t   a_integer,
    input  smfa_pkg::limb_t   a_fraction,
    input  wire               b_sign,
    input  smfa_pkg::limb_t   b_integer,
    input  smfa_pkg::limb_t   b_fraction,
    output logic              done,
    output logic              r_sign,
    output smfa_pkg::limb_t   r_integer,
    output smfa_pkg::limb_t   r_fraction
);
    import smfa_pkg::*;

    // Fraction limb survives only with two or more limbs
    localparam limb_t FRAC_KEEP = (LIMB_COUNT >= 2) ? '1 : '0;

    logic   accept;

    // Input register
    logic   v0_reg;
    cmd_t   cmd0_reg;
    logic   sa0_reg;
    logic   sb0_reg;
    mag_t   ma0_reg;
    mag_t   mb0_reg;

    // Stage one / two: add result and multiply sign ride along
    logic   v1_reg;
    logic   mul1_reg;
    logic   as_sign1_reg;
    mag_t   as_mag1_reg;
    logic   mul_sign1_reg;
    logic   v2_reg;
    logic   mul2_reg;
    logic   sign2_reg;
    mag_t   as_mag2_reg;

    // Result register
    logic   done_reg;
    logic   r_sign_reg;
    mag_t   r_mag_reg;

    logic   sb_eff;
    logic   is_mul;
    logic   as_sign_next;
    mag_t   as_mag_next;
    mag_t   sum_mag;
    mag_t   dab_mag;
    mag_t   dba_mag;
    logic   a_less;
    mag_t   prod;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Hold accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd0_reg <= command;
            sa0_reg  <= a_sign;
            sb0_reg  <= b_sign;
            ma0_reg  <= {a_integer, a_fraction & FRAC_KEEP};
            mb0_reg  <= {b_integer, b_fraction & FRAC_KEEP};
        end
    end

    // Decode command
    always_comb
    begin
        unique case (cmd0_reg)
            CMD_ADD:
            begin
                is_mul = 1'b0;
                sb_eff = sb0_reg;
            end
            CMD_SUB:
            begin
                is_mul = 1'b0;
                sb_eff = !sb0_reg;
            end
            default:
            begin
                is_mul = 1'b1;
                sb_eff = sb0_reg;
            end
        endcase
    end

    // Signed add: sum on like signs, else larger minus smaller
    always_comb
    begin
        sum_mag = ma0_reg + mb0_reg;
        dab_mag = ma0_reg - mb0_reg;
        dba_mag = mb0_reg - ma0_reg;
        a_less  = ma0_reg < mb0_reg;
        if (sa0_reg == sb_eff)
        begin
            as_mag_next  = sum_mag;
            as_sign_next = sa0_reg;
        end
        else if (a_less)
        begin
            as_mag_next  = dba_mag;
            as_sign_next = sb_eff;
        end
        else
        begin
            as_mag_next  = dab_mag;
            as_sign_next = sa0_reg;
        end
    end

    smfa_mul u_mul
    (
        .clk  (clk),
        .x    (ma0_reg),
        .y    (mb0_reg),
        .prod (prod)
    );

    // Advance valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= v0_reg;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    // Advance payload alongside the multiplier
    always_ff @(posedge clk)
    begin
        mul1_reg      <= is_mul;
        as_sign1_reg  <= as_sign_next;
        as_mag1_reg   <= as_mag_next;
        mul_sign1_reg <= sa0_reg ^ sb0_reg;

        mul2_reg      <= mul1_reg;
        sign2_reg     <= mul1_reg ? mul_sign1_reg : as_sign1_reg;
        as_mag2_reg   <= as_mag1_reg;

        r_sign_reg    <= sign2_reg;
        r_mag_reg     <= mul2_reg ? prod : as_mag2_reg;
    end

    // Drive result word
    assign done       = done_reg;
    assign r_sign     = r_sign_reg;
    assign r_integer  = r_mag_reg[MAG_BITS-1:LIMB_BITS];
    assign r_fraction = r_mag_reg[LIMB_BITS-1:0] & FRAC_KEEP;

    // Every accepted word produces a result on done
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
        else $error("accepted word did not produce a result on time");

    // No result without an accepted word
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 4))
        else $error("result strobe without an accepted word");

    // Multiply sign is the XOR of operand signs
    a_mul_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_MUL)
        |-> ##4 (r_sign == ($past(a_sign, 4) ^ $past(b_sign, 4))))
        else $error("multiply result sign wrong");

    // Like-signed add keeps a's sign
    a_add_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && command == CMD_ADD && a_sign == b_sign)
        |-> ##4 (r_sign == $past(a_sign, 4)))
        else $error("like-signed add changed sign");

endmodule : sign_magnitude_fixed_point_alu_core
`default_nettype wire

/* hdl/smfa_mul.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// smfa_mul
// Two-stage 64x64 magnitude multiplier. Returns ((x * y + 2^31) >> 32)
// modulo 2^64. Stage one forms four 32x32 partial products, stage two sums
// the middle and upper columns; the final carry and rounding increment are
// combinational on the output, ahead of the caller's result register.
// ----------------------------------------------------------------------------
module smfa_mul
(
    input  wire              clk,
    input  smfa_pkg::mag_t   x,
    input  smfa_pkg::mag_t   y,
    output smfa_pkg::mag_t   prod
);
    import smfa_pkg::*;

    // Stage one: partial products
    logic [MAG_BITS-1:0]   p0_reg;
    logic [MAG_BITS-1:0]   p1_reg;
    logic [MAG_BITS-1:0]   p2_reg;
    logic [LIMB_BITS-1:0]  p3_reg;

    // Stage two: column sums
    logic [LIMB_BITS+1:0]  mid_reg;
    logic [LIMB_BITS+1:0]  hs_reg;
    logic                  rnd_reg;

    logic [LIMB_BITS+1:0]  mid_next;
    logic [LIMB_BITS+1:0]  hs_next;
    logic [LIMB_BITS-1:0]  limb2;

    // Form the four partial products; only the low limb of the top one counts
    always_ff @(posedge clk)
    begin
        p0_reg <= MAG_BITS'(x[LIMB_BITS-1:0])        * MAG_BITS'(y[LIMB_BITS-1:0]);
        p1_reg <= MAG_BITS'(x[LIMB_BITS-1:0])        * MAG_BITS'(y[MAG_BITS-1:LIMB_BITS]);
        p2_reg <= MAG_BITS'(x[MAG_BITS-1:LIMB_BITS]) * MAG_BITS'(y[LIMB_BITS-1:0]);
        p3_reg <= LIMB_BITS'(x[MAG_BITS-1:LIMB_BITS] * y[MAG_BITS-1:LIMB_BITS]);
    end

    // Sum the middle column and the upper column without its incoming carry
    always_comb
    begin
        mid_next = (LIMB_BITS+2)'(p0_reg[MAG_BITS-1:LIMB_BITS])
                 + (LIMB_BITS+2)'(p1_reg[LIMB_BITS-1:0])
                 + (LIMB_BITS+2)'(p2_reg[LIMB_BITS-1:0]);
        hs_next  = (LIMB_BITS+2)'(p1_reg[MAG_BITS-1:LIMB_BITS])
                 + (LIMB_BITS+2)'(p2_reg[MAG_BITS-1:LIMB_BITS])
                 + (LIMB_BITS+2)'(p3_reg);
    end

    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
        hs_reg  <= hs_next;
        rnd_reg <= p0_reg[LIMB_BITS-1];
    end

    // Fold the middle carry into the upper limb, then round half up
    assign limb2 = LIMB_BITS'(hs_reg + (LIMB_BITS+2)'(mid_reg[LIMB_BITS+1:LIMB_BITS]));
    assign prod  = {limb2, mid_reg[LIMB_BITS-1:0]} + MAG_BITS'(rnd_reg);

endmodule : smfa_mul
`default_nettype wire
